/* src/rtwl_pkg.sv */
// ----------------------------------------------------------------------------
// rtwl_pkg: shared types and constants for the rotated triangle line emitter
// Holds field widths, register and copy codes, the job record passed from the
// front end to the back end, and the quarter sine generator for the ROM.
// ----------------------------------------------------------------------------
package rtwl_pkg;

    localparam int ANGLE_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 4;

    localparam int POS_W   = 16;
    localparam int RAD_W   = 12;
    localparam int COL_W   = 24;
    localparam int PIX_W   = 13;
    localparam int OFF_W   = 13;
    localparam int SCR_W   = 11;
    localparam int TRIG_W  = 15;
    localparam int TRIG_FRAC = 14;
    localparam int PROD_W  = RAD_W + TRIG_W;
    localparam int NCOPY   = 5;
    localparam int NTRIG   = 6;
    localparam int QDEPTH  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int PIX_MIN = -4096;
    localparam int PIX_MAX = 4095;

    localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = SCR_W'(640);
    localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = SCR_W'(480);

    // Coefficients of the quarter-wave sine polynomial.
    localparam longint unsigned SIN_A = 64'd102944;
    localparam longint unsigned SIN_B = 64'd42047;
    localparam longint unsigned SIN_C = 64'd4640;
    localparam longint unsigned SIN_ONE = 64'd16384;

    // Bit positions in the copy mask: the original, then one per crossed edge.
    localparam int COPY_ORIG = 0;
    localparam int COPY_XNEG = 1;
    localparam int COPY_XPOS = 2;
    localparam int COPY_YNEG = 3;
    localparam int COPY_YPOS = 4;

    // Slots of the six trig lookups.
    localparam int TI_MX = 0;
    localparam int TI_MY = 1;
    localparam int TI_PX = 2;
    localparam int TI_PY = 3;
    localparam int TI_TX = 4;
    localparam int TI_TY = 5;

    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEG_CM = 2'd0,
        SEG_CP = 2'd1,
        SEG_MT = 2'd2,
        SEG_PT = 2'd3
    } t_seg;

    typedef struct packed {
        logic [SCR_W-1:0] width;
        logic [SCR_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [OFF_W-1:0] off_mx;
        logic signed [OFF_W-1:0] off_my;
        logic signed [OFF_W-1:0] off_px;
        logic signed [OFF_W-1:0] off_py;
        logic signed [OFF_W-1:0] off_tx;
        logic signed [OFF_W-1:0] off_ty;
        logic [NCOPY-1:0]        copies;
        logic [COL_W-1:0]        colour;
    } t_job;

    // Magnitude of the sine over the first quarter turn, Q1.14.
    function automatic logic [TRIG_W-1:0] quarter_sine(input int unsigned u,
                                                       input int unsigned angle_bits);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned inner;
        longint unsigned mid;
        longint unsigned s;
        longint unsigned q;
        t     = 64'(u) << (16 - (angle_bits - 2));
        t2    = (t * t) >> 16;
        inner = SIN_B - ((SIN_C * t2) >> 16);
        mid   = SIN_A - ((t2 * inner) >> 16);
        s     = (t * mid) >> 16;
        q     = (s + 64'd2) >> 2;
        if (q > SIN_ONE) begin
            q = SIN_ONE;
        end
        return q[TRIG_W-1:0];
    endfunction

endpackage

/* src/rtwl_front.sv */
// ----------------------------------------------------------------------------
// rtwl_front: item intake and shape geometry
// Looks up six sine and cosine values, scales them by the radius, and builds a
// job with the point offsets and the mask of copies to draw.
// ----------------------------------------------------------------------------
module rtwl_front #(
    parameter int ANGLE_BITS = rtwl_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = rtwl_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic signed [rtwl_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [rtwl_pkg::POS_W-1:0] i_pos_y,
    input  logic [rtwl_pkg::RAD_W-1:0]        i_radius,
    input  logic [ANGLE_BITS-1:0]             i_angle,
    input  logic [rtwl_pkg::COL_W-1:0]        i_colour,
    input  rtwl_pkg::t_cfg                    i_cfg,
    output logic                              o_job_valid,
    output rtwl_pkg::t_job                    o_job,
    input  logic                              i_q_full
);
    import rtwl_pkg::*;

    localparam int UW      = ANGLE_BITS - 2;
    localparam int QUARTER = 1 << UW;
    localparam int SW      = ((SCR_W + FRAC_BITS) > POS_W ? (SCR_W + FRAC_BITS) : POS_W) + 2;
    localparam logic [ANGLE_BITS-1:0] QTR_A   = ANGLE_BITS'(QUARTER);
    localparam logic [ANGLE_BITS-1:0] THREE8  = ANGLE_BITS'(3 << (ANGLE_BITS - 3));
    localparam logic [PROD_W:0]       RND_HALF = (PROD_W + 1)'(1 << (TRIG_FRAC - 1));

    logic [TRIG_W-1:0] w_rom [QUARTER+1];
    logic [ANGLE_BITS-1:0] w_k [NTRIG];
    logic [ANGLE_BITS-1:0] w_am;
    logic [ANGLE_BITS-1:0] w_ap;
    logic w_adv;
    logic signed [SW-1:0] w_x;
    logic signed [SW-1:0] w_y;
    logic signed [SW-1:0] w_r;
    logic signed [SW-1:0] w_w;
    logic signed [SW-1:0] w_h;
    logic [NCOPY-1:0] w_copies;
    logic signed [OFF_W-1:0] w_off [NTRIG];

    // Stage A: table values
    logic r_va;
    logic signed [POS_W-1:0] r_xa;
    logic signed [POS_W-1:0] r_ya;
    logic [RAD_W-1:0] r_ra;
    logic [COL_W-1:0] r_cola;
    logic [NCOPY-1:0] r_cpa;
    logic [TRIG_W-1:0] r_mag [NTRIG];
    logic [NTRIG-1:0] r_nega;
    // Stage B: products
    logic r_vb;
    logic signed [POS_W-1:0] r_xb;
    logic signed [POS_W-1:0] r_yb;
    logic [COL_W-1:0] r_colb;
    logic [NCOPY-1:0] r_cpb;
    logic [PROD_W-1:0] r_prod [NTRIG];
    logic [NTRIG-1:0] r_negb;
    // Stage C: finished job
    logic r_vc;
    t_job r_job;

    function automatic logic [UW:0] rom_index(input logic [ANGLE_BITS-1:0] k);
        logic [UW:0] u;
        u = {1'b0, k[UW-1:0]};
        if (k[UW]) begin
            u = (UW + 1)'(QUARTER) - u;
        end
        return u;
    endfunction

    always_comb begin
        for (int i = 0; i <= QUARTER; i++) begin
            w_rom[i] = quarter_sine(i, ANGLE_BITS);
        end
    end

    assign w_am = i_angle - THREE8;
    assign w_ap = i_angle + THREE8;

    always_comb begin
        w_k[TI_MX] = w_am + QTR_A;
        w_k[TI_MY] = w_am;
        w_k[TI_PX] = w_ap + QTR_A;
        w_k[TI_PY] = w_ap;
        w_k[TI_TX] = i_angle + QTR_A;
        w_k[TI_TY] = i_angle;
    end

    // Wrap tests on the unshifted centre.
    assign w_x = SW'(i_pos_x);
    assign w_y = SW'(i_pos_y);
    assign w_r = $signed(SW'(i_radius));
    assign w_w = $signed(SW'(i_cfg.width) << FRAC_BITS);
    assign w_h = $signed(SW'(i_cfg.height) << FRAC_BITS);

    always_comb begin
        w_copies            = '0;
        w_copies[COPY_ORIG] = 1'b1;
        w_copies[COPY_XNEG] = (w_x + w_r) > w_w;
        w_copies[COPY_XPOS] = (w_x - w_r) < 0;
        w_copies[COPY_YNEG] = (w_y + w_r) > w_h;
        w_copies[COPY_YPOS] = (w_y - w_r) < 0;
    end

    // Round half away from zero, then put the sign back.
    always_comb begin
        for (int i = 0; i < NTRIG; i++) begin
            logic [PROD_W:0] rsum;
            logic signed [OFF_W-1:0] mag;
            rsum     = (PROD_W + 1)'(r_prod[i]) + RND_HALF;
            mag      = $signed(rsum[TRIG_FRAC +: OFF_W]);
            w_off[i] = r_negb[i] ? -mag : mag;
        end
    end

    assign w_adv       = !(r_vc && i_q_full);
    assign o_full      = !w_adv;
    assign o_job_valid = r_vc;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (w_adv) begin
            r_va <= i_push;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xa   <= i_pos_x;
            r_ya   <= i_pos_y;
            r_ra   <= i_radius;
            r_cola <= i_colour;
            r_cpa  <= w_copies;
            for (int i = 0; i < NTRIG; i++) begin
                r_mag[i]  <= w_rom[rom_index(w_k[i])];
                r_nega[i] <= w_k[i][ANGLE_BITS-1];
            end

            r_xb   <= r_xa;
            r_yb   <= r_ya;
            r_colb <= r_cola;
            r_cpb  <= r_cpa;
            r_negb <= r_nega;
            for (int i = 0; i < NTRIG; i++) begin
                r_prod[i] <= PROD_W'(r_ra) * PROD_W'(r_mag[i]);
            end

            r_job.pos_x  <= r_xb;
            r_job.pos_y  <= r_yb;
            r_job.off_mx <= w_off[TI_MX];
            r_job.off_my <= w_off[TI_MY];
            r_job.off_px <= w_off[TI_PX];
            r_job.off_py <= w_off[TI_PY];
            r_job.off_tx <= w_off[TI_TX];
            r_job.off_ty <= w_off[TI_TY];
            r_job.copies <= r_cpb;
            r_job.colour <= r_colb;
        end
    end

endmodule

/* src/rtwl_queue.sv */
// ----------------------------------------------------------------------------
// rtwl_queue: short job queue between the front end and the back end
// A small register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
module rtwl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rtwl_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output rtwl_pkg::t_job o_data,
    output logic           o_empty
);
    import rtwl_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_job r_mem [QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic w_push;
    logic w_pop;

    assign o_full  = r_cnt == CW'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= bump(r_wp);
            end
            if (w_pop) begin
                r_rp <= bump(r_rp);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* src/rtwl_back.sv */
// ----------------------------------------------------------------------------
// rtwl_back: segment sequencer and endpoint conversion
// Walks the copies and the four segments of each job, forms the endpoints,
// truncates them to integer pixels and holds each segment in an output register.
// ----------------------------------------------------------------------------
module rtwl_back #(
    parameter int FRAC_BITS = rtwl_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rtwl_pkg::t_cfg                    i_cfg,
    input  logic                              i_job_valid,
    input  rtwl_pkg::t_job                    i_job,
    output logic                              o_job_pop,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic signed [rtwl_pkg::PIX_W-1:0] o_x_start,
    output logic signed [rtwl_pkg::PIX_W-1:0] o_y_start,
    output logic signed [rtwl_pkg::PIX_W-1:0] o_x_end,
    output logic signed [rtwl_pkg::PIX_W-1:0] o_y_end,
    output logic [rtwl_pkg::COL_W-1:0]        o_line_colour,
    output logic                              o_last
);
    import rtwl_pkg::*;

    localparam int SW = ((SCR_W + FRAC_BITS) > POS_W ? (SCR_W + FRAC_BITS) : POS_W) + 2;
    localparam logic signed [SW-1:0] BIAS = SW'((1 << FRAC_BITS) - 1);

    logic r_busy;
    t_job r_job;
    logic [NCOPY-1:0] r_mask;
    t_seg r_seg;

    logic r_s1v;
    logic signed [SW-1:0] r_sx;
    logic signed [SW-1:0] r_sy;
    logic signed [SW-1:0] r_ex;
    logic signed [SW-1:0] r_ey;
    logic [COL_W-1:0] r_s1col;
    logic r_s1last;

    logic r_ov;
    logic signed [PIX_W-1:0] r_ox0;
    logic signed [PIX_W-1:0] r_oy0;
    logic signed [PIX_W-1:0] r_ox1;
    logic signed [PIX_W-1:0] r_oy1;
    logic [COL_W-1:0] r_ocol;
    logic r_olast;

    logic w_en;
    logic w_step;
    logic w_load;
    logic w_seg_end;
    logic w_done;
    logic [NCOPY-1:0] w_low;
    logic [NCOPY-1:0] w_rest;
    logic signed [SW-1:0] w_w;
    logic signed [SW-1:0] w_h;
    logic signed [SW-1:0] w_cx;
    logic signed [SW-1:0] w_cy;
    logic signed [OFF_W-1:0] w_osx;
    logic signed [OFF_W-1:0] w_osy;
    logic signed [OFF_W-1:0] w_oex;
    logic signed [OFF_W-1:0] w_oey;

    // Truncate toward zero, then saturate to the pixel range.
    function automatic logic signed [PIX_W-1:0] to_pix(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] b;
        logic signed [SW-1:0] q;
        b = (v < 0) ? v + BIAS : v;
        q = b >>> FRAC_BITS;
        if (q < PIX_MIN) begin
            q = SW'(PIX_MIN);
        end else if (q > PIX_MAX) begin
            q = SW'(PIX_MAX);
        end
        return q[PIX_W-1:0];
    endfunction

    assign w_en      = !r_ov || i_pop;
    assign w_step    = w_en && r_busy;
    assign w_low     = r_mask & (~r_mask + NCOPY'(1));
    assign w_rest    = r_mask & ~w_low;
    assign w_seg_end = r_seg == SEG_PT;
    assign w_done    = w_seg_end && (w_rest == '0);
    assign w_load    = i_job_valid && (!r_busy || (w_step && w_done));
    assign o_job_pop = w_load;

    assign w_w = $signed(SW'(i_cfg.width) << FRAC_BITS);
    assign w_h = $signed(SW'(i_cfg.height) << FRAC_BITS);

    always_comb begin
        w_cx = SW'(r_job.pos_x);
        w_cy = SW'(r_job.pos_y);
        if (w_low[COPY_XNEG]) begin
            w_cx = SW'(r_job.pos_x) - w_w;
        end else if (w_low[COPY_XPOS]) begin
            w_cx = SW'(r_job.pos_x) + w_w;
        end
        if (w_low[COPY_YNEG]) begin
            w_cy = SW'(r_job.pos_y) - w_h;
        end else if (w_low[COPY_YPOS]) begin
            w_cy = SW'(r_job.pos_y) + w_h;
        end
    end

    always_comb begin
        case (r_seg)
            SEG_CM: begin
                w_osx = '0;
                w_osy = '0;
                w_oex = r_job.off_mx;
                w_oey = r_job.off_my;
            end
            SEG_CP: begin
                w_osx = '0;
                w_osy = '0;
                w_oex = r_job.off_px;
                w_oey = r_job.off_py;
            end
            SEG_MT: begin
                w_osx = r_job.off_mx;
                w_osy = r_job.off_my;
                w_oex = r_job.off_tx;
                w_oey = r_job.off_ty;
            end
            SEG_PT: begin
                w_osx = r_job.off_px;
                w_osy = r_job.off_py;
                w_oex = r_job.off_tx;
                w_oey = r_job.off_ty;
            end
            default: begin
                w_osx = '0;
                w_osy = '0;
                w_oex = r_job.off_mx;
                w_oey = r_job.off_my;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seg  <= SEG_CM;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_seg  <= SEG_CM;
        end else if (w_step) begin
            if (w_seg_end) begin
                r_seg <= SEG_CM;
                if (w_rest == '0) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_seg <= t_seg'(r_seg + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job  <= i_job;
            r_mask <= i_job.copies;
        end else if (w_step && w_seg_end) begin
            r_mask <= w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r_s1v <= r_busy;
            r_ov  <= r_s1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx     <= w_cx + SW'(w_osx);
            r_sy     <= w_cy + SW'(w_osy);
            r_ex     <= w_cx + SW'(w_oex);
            r_ey     <= w_cy + SW'(w_oey);
            r_s1col  <= r_job.colour;
            r_s1last <= w_done;

            r_ox0   <= to_pix(r_sx);
            r_oy0   <= to_pix(r_sy);
            r_ox1   <= to_pix(r_ex);
            r_oy1   <= to_pix(r_ey);
            r_ocol  <= r_s1col;
            r_olast <= r_s1last;
        end
    end

    assign o_empty       = !r_ov;
    assign o_x_start     = r_ox0;
    assign o_y_start     = r_oy0;
    assign o_x_end       = r_ox1;
    assign o_y_end       = r_oy1;
    assign o_line_colour = r_ocol;
    assign o_last        = r_olast;

endmodule

/* src/rotated_triangle_wrap_line_emitter.sv */
// ----------------------------------------------------------------------------
// rotated_triangle_wrap_line_emitter: triangle outline segments with wrap
// Turns a centre, radius, heading and colour into the line segments of a
// triangle outline, with extra copies shifted by the screen size where the
// shape crosses a screen edge.
// ----------------------------------------------------------------------------
//
// Channel        Direction  Handshake                     Moves
// -------------  ---------  ----------------------------  -----------------------
// shape items    in         push / full                   pos, radius, angle, colour
// segments       out        empty / pop                   endpoints, colour, last
// registers      in/out     psel / penable / pready       screen width and height
//
// Each item gives four segments per drawn copy, so 4, 8, 12, 16 or 20 segments;
// the back end emits one segment per cycle while its segments are popped.
// The front end takes one item per cycle while full is low and builds its job
// in table, product and job registers; a two-entry job queue sits between the
// two ends, so the next items are taken while the current one is being emitted.
// Reset is synchronous and active low: it empties the pipelines and the queue
// and sets the screen size to 640 by 480. There is no clearing pass.
// full rises when the front end's last stage holds a job and the queue is full;
// a segment that is not popped holds the back end in place.
//
// The front end reads a quarter-wave sine table at six angles (tip, and the two
// back points at three eighths of a turn either side; sine and cosine each),
// multiplies each value by the radius and rounds to the position format. It
// also decides which wrap copies are needed from the unshifted centre. The
// back end walks the copy mask, lowest bit first, and for each copy emits the
// segments centre to back points, then back points to tip. Endpoints are
// formed in a register stage and truncated toward zero and saturated in the
// output register.
// ----------------------------------------------------------------------------
module rotated_triangle_wrap_line_emitter #(
    parameter int ANGLE_BITS = rtwl_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = rtwl_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // shape items
    input  logic                                push,
    output logic                                full,
    input  logic signed [rtwl_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [rtwl_pkg::POS_W-1:0]   i_pos_y,
    input  logic [rtwl_pkg::RAD_W-1:0]          i_radius,
    input  logic [ANGLE_BITS-1:0]               i_angle,
    input  logic [rtwl_pkg::COL_W-1:0]          i_colour,
    // segments
    output logic                                empty,
    input  logic                                pop,
    output logic signed [rtwl_pkg::PIX_W-1:0]   o_x_start,
    output logic signed [rtwl_pkg::PIX_W-1:0]   o_y_start,
    output logic signed [rtwl_pkg::PIX_W-1:0]   o_x_end,
    output logic signed [rtwl_pkg::PIX_W-1:0]   o_y_end,
    output logic [rtwl_pkg::COL_W-1:0]          o_line_colour,
    output logic                                o_last,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rtwl_pkg::PADDR_W-1:0]        paddr,
    input  logic [rtwl_pkg::PDATA_W-1:0]        pwdata,
    output logic [rtwl_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import rtwl_pkg::*;

    logic [SCR_W-1:0] r_screen_width;
    logic [SCR_W-1:0] r_screen_height;
    logic [SCR_W-1:0] n_screen_width;
    logic [SCR_W-1:0] n_screen_height;
    logic w_wr;
    t_reg_idx w_idx;
    t_cfg w_cfg;

    logic w_job_valid;
    t_job w_job;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;
    t_job w_q_data;

    // Register port. The registers are one word apart; the low address bits
    // are ignored.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[2]);

    always_comb begin
        n_screen_width  = r_screen_width;
        n_screen_height = r_screen_height;
        if (w_wr) begin
            case (w_idx)
                REG_SCREEN_WIDTH:  n_screen_width  = pwdata[SCR_W-1:0];
                REG_SCREEN_HEIGHT: n_screen_height = pwdata[SCR_W-1:0];
                default: begin
                    n_screen_width  = r_screen_width;
                    n_screen_height = r_screen_height;
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SCREEN_WIDTH:  prdata = PDATA_W'(r_screen_width);
            REG_SCREEN_HEIGHT: prdata = PDATA_W'(r_screen_height);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
        end else begin
            r_screen_width  <= n_screen_width;
            r_screen_height <= n_screen_height;
        end
    end

    assign w_cfg.width  = r_screen_width;
    assign w_cfg.height = r_screen_height;

    rtwl_front #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_radius    (i_radius),
        .i_angle     (i_angle),
        .i_colour    (i_colour),
        .i_cfg       (w_cfg),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_q_full    (w_q_full)
    );

    rtwl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_valid),
        .i_data  (w_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    rtwl_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_job_valid   (!w_q_empty),
        .i_job         (w_q_data),
        .o_job_pop     (w_q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_x_start     (o_x_start),
        .o_y_start     (o_y_start),
        .o_x_end       (o_x_end),
        .o_y_end       (o_y_end),
        .o_line_colour (o_line_colour),
        .o_last        (o_last)
    );

    // The segment output is empty right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("segment output not empty after reset");

    // The front end only stalls because the job queue is full.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_q_full)
        else $error("front end stalled without a full job queue");

    // The back end never takes a job from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("job taken from an empty queue");

endmodule
